FILE: rtl/ptpd_pkg.sv
// Package for the pen/touch packet deframer: beat types, codes and state layout.
`default_nettype none
package ptpd_pkg;

  localparam int unsigned PenPayloadBytesDef = 22;
  localparam int unsigned FingerSlotBytesDef = 10;
  localparam int unsigned MaxFingersRst      = 10;

  // Long enough for 15 fingers of 16-byte slots or 64 pen bytes.
  localparam int unsigned LenW = 8;

  localparam logic [7:0] TypePen       = 8'h01;
  localparam logic [7:0] TypeTouch     = 8'h02;
  localparam logic [7:0] TypeHeartbeat = 8'h03;
  localparam int unsigned HeartbeatLen   = 3;
  localparam int unsigned TouchHeaderLen = 2;

  typedef enum logic [2:0] {
    PhType      = 3'd0,
    PhHeartbeat = 3'd1,
    PhCount     = 3'd2,
    PhPayload   = 3'd3,
    PhDiscard   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KindPen      = 2'd0,
    KindTouch    = 2'd1,
    KindBadCount = 2'd2,
    KindBadType  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       transfer_end;
  } in_beat_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_byte;
    logic [6:0] byte_index;
    logic [3:0] finger_count;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    phase_e          phase;
    logic [LenW-1:0] bytes_left;
    logic [LenW-1:0] payload_pos;
    logic            packet_kind;
    logic [3:0]      held_count;
  } dfr_state_t;

endpackage
`default_nettype wire

FILE: rtl/ptpd_step.sv
// Next-state and result logic for one input beat of the deframer.
`default_nettype none
module ptpd_step import ptpd_pkg::*; #(
  parameter int unsigned PenPayloadBytes = PenPayloadBytesDef,
  parameter int unsigned FingerSlotBytes = FingerSlotBytesDef
) (
  input  dfr_state_t state_i,
  input  in_beat_t   beat_i,
  input  logic [3:0] max_fingers_i,
  output dfr_state_t state_o,
  output logic       emit_o,
  output out_beat_t  res_o
);

  logic [LenW-1:0] left_dec;
  logic            pay_last;

  assign left_dec = (state_i.bytes_left == '0) ? '0 : state_i.bytes_left - LenW'(1);
  assign pay_last = (state_i.bytes_left <= LenW'(1));

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    res_o   = '{kind: KindBadType, payload_byte: 8'h00, byte_index: 7'd0,
                finger_count: 4'd0, last: 1'b1};
    case (state_i.phase)
      PhHeartbeat: begin
        state_o.bytes_left = left_dec;
        if (left_dec == '0) state_o.phase = PhType;
      end
      PhCount: begin
        if (beat_i.data_byte == 8'h00 || beat_i.data_byte > {4'h0, max_fingers_i}) begin
          emit_o           = 1'b1;
          res_o.kind       = KindBadCount;
          state_o.phase    = beat_i.transfer_end ? PhType : PhDiscard;
          state_o.bytes_left  = '0;
          state_o.payload_pos = '0;
        end else begin
          state_o.held_count  = beat_i.data_byte[3:0];
          state_o.bytes_left  = LenW'(beat_i.data_byte[3:0]) * LenW'(FingerSlotBytes);
          state_o.payload_pos = '0;
          state_o.phase       = PhPayload;
        end
      end
      PhPayload: begin
        emit_o             = 1'b1;
        res_o.kind         = state_i.packet_kind ? KindTouch : KindPen;
        res_o.payload_byte = beat_i.data_byte;
        res_o.byte_index   = state_i.payload_pos[6:0];
        res_o.finger_count = state_i.packet_kind ? state_i.held_count : 4'd0;
        res_o.last         = pay_last;
        state_o.payload_pos = state_i.payload_pos + LenW'(1);
        state_o.bytes_left  = left_dec;
        if (pay_last) begin
          state_o.phase       = PhType;
          state_o.bytes_left  = '0;
          state_o.payload_pos = '0;
        end
      end
      PhDiscard: begin
        if (beat_i.transfer_end) state_o.phase = PhType;
      end
      default: begin
        if (beat_i.data_byte == TypeHeartbeat) begin
          state_o.bytes_left = LenW'(HeartbeatLen - 1);
          state_o.phase      = PhHeartbeat;
        end else if (beat_i.data_byte == TypePen) begin
          state_o.packet_kind = 1'b0;
          state_o.held_count  = 4'd0;
          state_o.bytes_left  = LenW'(PenPayloadBytes);
          state_o.payload_pos = '0;
          state_o.phase       = PhPayload;
        end else if (beat_i.data_byte == TypeTouch) begin
          state_o.packet_kind = 1'b1;
          state_o.bytes_left  = LenW'(TouchHeaderLen - 1);
          state_o.payload_pos = '0;
          state_o.phase       = PhCount;
        end else begin
          emit_o              = 1'b1;
          res_o.kind          = KindBadType;
          state_o.phase       = beat_i.transfer_end ? PhType : PhDiscard;
          state_o.bytes_left  = '0;
          state_o.payload_pos = '0;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/pen_touch_packet_deframer.sv
// Top level of the pen/touch packet deframer.
// Takes one stream byte per cycle and emits pen or touch payload bytes tagged with
// kind, index, finger count and a last mark; heartbeats are dropped, and a bad type
// or finger count gives one error beat and discards to the end of the transfer.
// Each accepted byte is decoded into the state and result registers, so results
// appear in the cycle after acceptance and a byte can be taken every cycle;
// in_ready_o is high while the result register is empty or being taken. The user
// writes max_fingers via cfg_we_i / cfg_wdata_i only while idle; it is not enforced.
`default_nettype none
module pen_touch_packet_deframer import ptpd_pkg::*; #(
  parameter int unsigned PenPayloadBytes = PenPayloadBytesDef,
  parameter int unsigned FingerSlotBytes = FingerSlotBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_beat_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_beat_t  out_data_o
);

  dfr_state_t state_q, state_d;
  logic [3:0] max_fingers_q;
  logic       out_valid_q;
  out_beat_t  out_data_q;
  logic       emit;
  out_beat_t  res;
  logic       in_acc;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_acc     = in_valid_i & in_ready_o;

  ptpd_step #(
    .PenPayloadBytes(PenPayloadBytes),
    .FingerSlotBytes(FingerSlotBytes)
  ) u_step (
    .state_i      (state_q),
    .beat_i       (in_data_i),
    .max_fingers_i(max_fingers_q),
    .state_o      (state_d),
    .emit_o       (emit),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= '{phase: PhType, bytes_left: '0, payload_pos: '0,
                         packet_kind: 1'b0, held_count: 4'd0};
      max_fingers_q <= 4'(MaxFingersRst);
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) max_fingers_q <= cfg_wdata_i;
      if (in_acc) begin
        state_q     <= state_d;
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) out_data_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

FILE: rtl/ptpd_checker.sv
// Port-level checks for the pen/touch packet deframer, bound to the top level.
`default_nettype none
module ptpd_checker import ptpd_pkg::*; #(
  parameter int unsigned PenPayloadBytes = PenPayloadBytesDef
) (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_beat_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KindBadCount || out_data_o.kind == KindBadType)
    |-> out_data_o.last && out_data_o.payload_byte == 8'h00 &&
        out_data_o.byte_index == 7'd0 && out_data_o.finger_count == 4'd0)
    else $error("error beat carries payload");

  a_pen_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindPen
    |-> out_data_o.finger_count == 4'd0 &&
        out_data_o.byte_index < 7'(PenPayloadBytes) &&
        (out_data_o.last == (out_data_o.byte_index == 7'(PenPayloadBytes - 1))))
    else $error("pen beat index or last mark wrong");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

bind pen_touch_packet_deframer ptpd_checker #(
  .PenPayloadBytes(PenPayloadBytes)
) u_ptpd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
`default_nettype wire

FILE: tb/tb_pen_touch_packet_deframer.sv
// Self-checking testbench for the pen/touch packet deframer.
`timescale 1ns / 100ps
module tb_pen_touch_packet_deframer;
  import ptpd_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [3:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready_o;
  in_beat_t   in_data;
  logic       out_valid_o;
  logic       out_ready;
  out_beat_t  out_data_o;

  pen_touch_packet_deframer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  // Deframer state as predicted
  phase_e      dfr_phase;
  int unsigned left_cnt;
  int unsigned pos_cnt;
  bit          is_touch;
  logic [3:0]  fingers_held;
  logic [3:0]  max_fingers_cfg;

  out_beat_t   due_beats[$];
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned n_payload;
  int unsigned n_errors;
  bit          idle_on;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned stall_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("timeout: %0d beats still due", due_beats.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void drop_packet(input bit at_end);
    dfr_phase = at_end ? PhType : PhDiscard;
    left_cnt  = 0;
    pos_cnt   = 0;
  endfunction

  function automatic bit deframe_byte(input in_beat_t ib, output out_beat_t ob);
    logic [7:0] d;
    bit         e;
    bit         fin;
    d  = ib.data_byte;
    e  = ib.transfer_end;
    ob = '0;
    case (dfr_phase)
      PhHeartbeat: begin
        if (left_cnt > 0) left_cnt--;
        if (left_cnt == 0) dfr_phase = PhType;
        return 1'b0;
      end
      PhCount: begin
        if (d == 8'd0 || d > max_fingers_cfg) begin
          ob.kind = KindBadCount;
          ob.last = 1'b1;
          drop_packet(e);
          return 1'b1;
        end
        fingers_held = d[3:0];
        left_cnt     = fingers_held * FingerSlotBytesDef;
        pos_cnt      = 0;
        dfr_phase    = PhPayload;
        return 1'b0;
      end
      PhPayload: begin
        fin             = (left_cnt <= 1);
        ob.kind         = is_touch ? KindTouch : KindPen;
        ob.payload_byte = d;
        ob.byte_index   = pos_cnt[6:0];
        ob.finger_count = is_touch ? fingers_held : 4'd0;
        ob.last         = fin;
        pos_cnt++;
        if (left_cnt > 0) left_cnt--;
        if (fin) begin
          dfr_phase = PhType;
          left_cnt  = 0;
          pos_cnt   = 0;
        end
        return 1'b1;
      end
      PhDiscard: begin
        if (e) dfr_phase = PhType;
        return 1'b0;
      end
      default: ;
    endcase
    if (d == TypeHeartbeat) begin
      left_cnt  = HeartbeatLen - 1;
      dfr_phase = PhHeartbeat;
      return 1'b0;
    end
    if (d == TypePen) begin
      is_touch     = 1'b0;
      fingers_held = 4'd0;
      left_cnt     = PenPayloadBytesDef;
      pos_cnt      = 0;
      dfr_phase    = PhPayload;
      return 1'b0;
    end
    if (d == TypeTouch) begin
      is_touch  = 1'b1;
      left_cnt  = TouchHeaderLen - 1;
      pos_cnt   = 0;
      dfr_phase = PhCount;
      return 1'b0;
    end
    ob.kind = KindBadType;
    ob.last = 1'b1;
    drop_packet(e);
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input out_beat_t want, input out_beat_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: want kind %0d byte %02h idx %0d cnt %0d last %0b",
               $time, what, want.kind, want.payload_byte, want.byte_index,
               want.finger_count, want.last);
      $display("%0t %s:  got kind %0d byte %02h idx %0d cnt %0d last %0b",
               $time, what, got.kind, got.payload_byte, got.byte_index,
               got.finger_count, got.last);
    end
  endtask

  // Result check first, then prediction for the byte taken at this edge
  always @(posedge clk_i) begin : scoreboard
    out_beat_t want;
    out_beat_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        got = out_data_o;
        if (due_beats.size() == 0) begin
          flag_mismatch("unexpected beat", '0, got);
        end else begin
          want = due_beats.pop_front();
          if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
              got.byte_index !== want.byte_index || got.finger_count !== want.finger_count ||
              got.last !== want.last)
            flag_mismatch("beat mismatch", want, got);
          if (want.kind == KindPen || want.kind == KindTouch) n_payload++;
          else n_errors++;
        end
      end
      if (in_valid && in_ready_o) begin
        if (deframe_byte(in_data, want)) due_beats.push_back(want);
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 120;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Entered and left at a falling edge
  task automatic send_byte(input logic [7:0] d, input bit e);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= {d, e};
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic bit rand_end();
    return $urandom_range(0, 7) == 0;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_beats.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_max_fingers(input logic [3:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we          <= 1'b0;
    max_fingers_cfg = v;
  endtask

  task automatic send_touch(input logic [7:0] count);
    send_byte(TypeTouch, rand_end());
    send_byte(count, rand_end());
    if (count != 0 && count <= max_fingers_cfg)
      repeat (count * FingerSlotBytesDef) send_byte(8'($urandom_range(0, 255)), rand_end());
  endtask

  task automatic send_traffic(input int unsigned n);
    int unsigned stop;
    int unsigned r;
    int unsigned cnt;
    logic [7:0]  b;
    stop = bytes_sent + n;
    while (bytes_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_byte(TypePen, rand_end());
        repeat (PenPayloadBytesDef) send_byte(8'($urandom_range(0, 255)), rand_end());
      end else if (r < 60) begin
        if (max_fingers_cfg == 0) cnt = 1;
        else if ($urandom_range(0, 4) != 0)
          cnt = $urandom_range(1, (max_fingers_cfg < 3) ? max_fingers_cfg : 3);
        else cnt = $urandom_range(1, max_fingers_cfg);
        send_touch(8'(cnt));
      end else if (r < 72) begin
        send_byte(TypeHeartbeat, rand_end());
        send_byte(8'($urandom_range(0, 255)), rand_end());
        send_byte(8'($urandom_range(0, 255)), rand_end());
      end else if (r < 82) begin
        do b = 8'($urandom_range(0, 255));
        while (b == TypePen || b == TypeTouch || b == TypeHeartbeat);
        send_byte(b, rand_end());
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)), rand_end());
      end else if (r < 92) begin
        if ($urandom_range(0, 1) == 0 || max_fingers_cfg == 4'd15) b = 8'd0;
        else b = 8'($urandom_range(max_fingers_cfg + 1, 255));
        if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(16, 255));
        send_touch(b);
      end else begin
        send_byte(8'($urandom_range(0, 255)), rand_end());
      end
    end
  endtask

  task automatic test_heartbeat_skip();
    send_byte(TypeHeartbeat, 1'b1);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(TypeHeartbeat, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_unknown_type();
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(TypePen, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h04, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_finger_count();
    send_byte(TypeTouch, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7E, 1'b1);
    send_byte(TypeTouch, 1'b1);
    send_byte(8'd11, 1'b1);
    send_byte(TypeTouch, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_touch_across_transfer();
    send_byte(TypeTouch, 1'b0);
    send_byte(8'd1, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    for (int i = 2; i < FingerSlotBytesDef; i++)
      send_byte(8'($urandom_range(0, 255)), i == 5);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_req = 1'b1;
    send_byte(TypePen, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    repeat (PenPayloadBytesDef - 2) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_traffic(20);
    wait_drained();
    send_traffic(20);
  endtask

  task automatic test_register_settings();
    send_traffic(80);
    write_max_fingers(4'd0);
    send_byte(TypeTouch, 1'b0);
    send_byte(8'd1, 1'b1);
    send_traffic(40);
    write_max_fingers(4'd1);
    send_byte(TypeTouch, 1'b0);
    send_byte(8'd2, 1'b1);
    send_traffic(100);
    write_max_fingers(4'd15);
    send_touch(8'd15);
    send_traffic(100);
    repeat (2) begin
      write_max_fingers(4'($urandom_range(1, 15)));
      send_traffic(60);
    end
    write_max_fingers(4'(MaxFingersRst));
  endtask

  task automatic test_full_rate();
    wait_drained();
    idle_on = 1'b0;
    repeat (12) @(negedge clk_i);
    send_traffic(100);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_ready       = 1'b0;
    idle_on         = 1'b1;
    hold_req        = 1'b0;
    hold_left       = 0;
    stall_left      = 0;
    mismatches      = 0;
    bytes_sent      = 0;
    n_payload       = 0;
    n_errors        = 0;
    dfr_phase       = PhType;
    left_cnt        = 0;
    pos_cnt         = 0;
    is_touch        = 1'b0;
    fingers_held    = '0;
    max_fingers_cfg = 4'(MaxFingersRst);
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_heartbeat_skip();
    test_unknown_type();
    test_finger_count();
    test_touch_across_transfer();
    test_backpressure();
    test_register_settings();
    test_full_rate();

    wait_drained();
    repeat (6) @(negedge clk_i);
    if (due_beats.size() != 0) begin
      mismatches++;
      $display("%0d expected beats never arrived", due_beats.size());
    end
    $display("%0d bytes in: %0d payload beats and %0d error beats checked", bytes_sent,
             n_payload, n_errors);
    $display("finger limits 10, 0, 1, 15 and random; long hold and full-rate stretch done");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
